// ----- sv/bbl_pkg.sv -----
// Shared constants for the 11x11 box blur: image limits, kernel geometry,
// datapath widths, register indexes and the reciprocal used for the divide.
// No dependencies.
`default_nettype none

package bbl_pkg;

    localparam int MAX_WIDTH     = 512;
    localparam int MAX_HEIGHT    = 4096;
    localparam int KERNEL_RADIUS = 5;

    localparam int KSIZE      = 2 * KERNEL_RADIUS + 1;
    localparam int STORE_ROWS = 2 * KERNEL_RADIUS;

    // field and register widths
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 10;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(STORE_ROWS);

    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int STORE_AW    = SLOT_W + COL_W;

    localparam int VSUM_W = 12;
    localparam int WT_W   = 15;

    // blur divide: floor(x / 121) == (x * RECIP_MULT) >> RECIP_SHIFT for x < 2**WT_W
    localparam int DIVISOR     = 121;
    localparam int ALPHA_MAX   = 255;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int PROD_W      = WT_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 10'd512;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd256;

endpackage

`default_nettype wire

// ----- sv/bbl_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while the read enable is low. No dependencies.
`default_nettype none

module bbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/box_blur_11x11.sv -----
// Streaming 11x11 box blur of an 8-bit alpha image.
// Depends on bbl_pkg and bbl_ram (line store and per-column partial sums).
//
// Usage:
//   Input channel: one pixel per item in raster order on i_pixel_alpha,
//   handshake i_in_valid / o_in_stall. Output channel: one item per centre
//   whose whole 11x11 window lies inside the image, with o_centre_x,
//   o_centre_y and o_blurred_alpha, handshake o_out_valid / i_out_stall.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 image_width, 1 image_height); write only while the block is idle.
//   Throughput: one pixel per clock while the output is not stalled. Each pixel does one
//   read-modify-write of the line store and of the column partial-sum RAM,
//   one read per cycle on each RAM port.
//   Path: the result for centre (x, y) passes the RAM-data, running-sum and
//   divide stages to the output register once pixel (x+5, y+5) is accepted.
//   Reset: counters, running sum and pipeline valid flags clear on reset; the line
//   store is not cleared, entries not yet written read as zero during the
//   first ten rows after reset. Sizes return to 512 x 256.
//   Stall: pipeline stages fill while the output is stalled; o_in_stall rises
//   only once every stage holds an item.
`default_nettype none

module box_blur_11x11
    import bbl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [PIX_W-1:0]        i_pixel_alpha,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [COL_W-1:0]        o_centre_x,
    output logic      [ROW_W-1:0]        o_centre_y,
    output logic      [PIX_W-1:0]        o_blurred_alpha
);

    // configuration
    logic [WIDTH_REG_W-1:0]  r_cfg_width;
    logic [HEIGHT_REG_W-1:0] r_cfg_height;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    // position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;
    logic              r_primed;
    logic [WIDTH_REG_W:0]  col_next;
    logic [HEIGHT_REG_W:0] row_next;
    logic              col_last;
    logic              row_last;
    logic              acc;

    // pipeline handshake
    logic ready1, ready2, ready3, ready4, ready_out;
    logic mv1, mv2;

    // stage 1: RAM data
    logic              r_v1;
    logic [PIX_W-1:0]  r_p1;
    logic [COL_W-1:0]  r_c1;
    logic [ROW_W-1:0]  r_r1;
    logic [SLOT_W-1:0] r_slot1;
    logic              r_zold1;
    logic              r_zs1;
    logic [PIX_W-1:0]  store_rdata;
    logic [VSUM_W-1:0] s10_rdata;
    logic [PIX_W-1:0]  old_pix;
    logic [VSUM_W-1:0] s10;
    logic [VSUM_W-1:0] vsum1;
    logic [VSUM_W-1:0] new_s10;

    // stage 2: horizontal running sum
    logic              r_v2;
    logic [VSUM_W-1:0] r_vsum2;
    logic [COL_W-1:0]  r_c2;
    logic [ROW_W-1:0]  r_r2;
    logic [VSUM_W-1:0] r_vline [KSIZE];
    logic [WT_W-1:0]   r_wt;
    logic [WT_W-1:0]   wt_next;
    logic              produce2;

    // stage 3 / 4: divide
    logic              r_v3;
    logic [WT_W-1:0]   r_wt3;
    logic [COL_W-1:0]  r_x3;
    logic [ROW_W-1:0]  r_y3;
    logic              r_v4;
    logic [PROD_W-1:0] r_prod4;
    logic [COL_W-1:0]  r_x4;
    logic [ROW_W-1:0]  r_y4;
    logic [QUOT_W-1:0] quot4;

    // output register
    logic              r_ov;
    logic [COL_W-1:0]  r_ox;
    logic [ROW_W-1:0]  r_oy;
    logic [PIX_W-1:0]  r_oa;

    always_comb begin
        if (r_cfg_width < WIDTH_REG_W'(KSIZE)) begin
            w_eff = WIDTH_REG_W'(KSIZE);
        end else if (r_cfg_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_width;
        end
        if (r_cfg_height < HEIGHT_REG_W'(KSIZE)) begin
            h_eff = HEIGHT_REG_W'(KSIZE);
        end else if (r_cfg_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    assign col_next = (WIDTH_REG_W + 1)'(r_col) + 1'b1;
    assign row_next = (HEIGHT_REG_W + 1)'(r_row) + 1'b1;
    assign col_last = col_next >= {1'b0, w_eff};
    assign row_last = row_next >= {1'b0, h_eff};

    assign ready_out = !r_ov || !i_out_stall;
    assign ready4    = !r_v4 || ready_out;
    assign ready3    = !r_v3 || ready4;
    assign ready2    = !r_v2 || ready3;
    assign ready1    = !r_v1 || ready2;
    assign o_in_stall = !ready1;
    assign acc = i_in_valid && ready1;
    assign mv1 = r_v1 && ready2;
    assign mv2 = r_v2 && ready3;

    // line store: slot-major, one row of MAX_WIDTH per slot
    bbl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mv1),
        .i_waddr ({r_slot1, r_c1}),
        .i_wdata (r_p1),
        .i_re    (acc),
        .i_raddr ({r_slot, r_col}),
        .o_rdata (store_rdata)
    );

    // per column: sum of the ten stored rows
    bbl_ram #(
        .WIDTH (VSUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_s10 (
        .i_clk   (i_clk),
        .i_we    (mv1),
        .i_waddr (r_c1),
        .i_wdata (new_s10),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (s10_rdata)
    );

    always_comb begin
        old_pix = r_zold1 ? '0 : store_rdata;
        s10     = r_zs1 ? '0 : s10_rdata;
        vsum1   = s10 + VSUM_W'(r_p1);
        new_s10 = vsum1 - VSUM_W'(old_pix);
    end

    always_comb begin
        if (r_c2 == '0) begin
            wt_next = WT_W'(r_vsum2);
        end else if (r_c2 < COL_W'(KSIZE)) begin
            wt_next = r_wt + WT_W'(r_vsum2);
        end else begin
            wt_next = r_wt + WT_W'(r_vsum2) - WT_W'(r_vline[KSIZE-1]);
        end
        produce2 = (r_c2 >= COL_W'(KSIZE - 1)) && (r_r2 >= ROW_W'(KSIZE - 1));
    end

    assign quot4 = r_prod4[PROD_W-1:RECIP_SHIFT];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_primed <= 1'b0;
            r_wt     <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                if (col_last) begin
                    r_col <= '0;
                    if (r_row == ROW_W'(STORE_ROWS - 1)) begin
                        r_primed <= 1'b1;
                    end
                    if (row_last) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= row_next[ROW_W-1:0];
                        r_slot <= (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
                    end
                end else begin
                    r_col <= col_next[COL_W-1:0];
                end
            end
            if (mv2) begin
                r_wt <= wt_next;
            end
            if (ready1)    r_v1 <= acc;
            if (ready2)    r_v2 <= r_v1;
            if (ready3)    r_v3 <= r_v2 && produce2;
            if (ready4)    r_v4 <= r_v3;
            if (ready_out) r_ov <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p1    <= i_pixel_alpha;
            r_c1    <= r_col;
            r_r1    <= r_row;
            r_slot1 <= r_slot;
            r_zold1 <= !r_primed;
            r_zs1   <= !r_primed && (r_row == '0);
        end
        if (mv1) begin
            r_vsum2 <= vsum1;
            r_c2    <= r_c1;
            r_r2    <= r_r1;
        end
        if (mv2) begin
            r_vline[0] <= r_vsum2;
            for (int i = 1; i < KSIZE; i++) begin
                r_vline[i] <= r_vline[i-1];
            end
            r_wt3 <= wt_next;
            r_x3  <= r_c2 - COL_W'(KERNEL_RADIUS);
            r_y3  <= r_r2 - ROW_W'(KERNEL_RADIUS);
        end
        if (ready4 && r_v3) begin
            r_prod4 <= PROD_W'(r_wt3) * PROD_W'(RECIP_MULT);
            r_x4    <= r_x3;
            r_y4    <= r_y3;
        end
        if (ready_out && r_v4) begin
            r_ox <= r_x4;
            r_oy <= r_y4;
            r_oa <= (quot4 > QUOT_W'(ALPHA_MAX)) ? PIX_W'(ALPHA_MAX) : quot4[PIX_W-1:0];
        end
    end

    assign o_out_valid     = r_ov;
    assign o_centre_x      = r_ox;
    assign o_centre_y      = r_oy;
    assign o_blurred_alpha = r_oa;

    // the write-back of an item never lands on the entry being read for the next one
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv1 && acc) |-> ({r_slot1, r_c1} != {r_slot, r_col}))
        else $error("line store read overlaps pending write-back");

    // input is held off only when stage 1 is occupied and cannot drain
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_ov))
        else $error("input stalled with an empty stage");

    // once ten rows have been stored, the store stays primed until reset
    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped");

    // a row end restarts the column counter
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && col_last) |=> (r_col == '0))
        else $error("column counter did not wrap");

    // a result only comes from a centre at least the kernel radius from the left edge
    a_centre_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv2 && produce2) |-> (r_c2 >= COL_W'(KSIZE - 1)))
        else $error("result for a column with an incomplete window");

endmodule

`default_nettype wire

// ----- tb/box_blur_11x11_chk.sv -----
// Checker for box_blur_11x11: follows the config port and both channels, models
// the line store, column sums and running window sum, and compares each result.
// Depends on bbl_pkg.
`default_nettype none

module box_blur_11x11_chk
    import bbl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [PIX_W-1:0]      i_pixel_alpha,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [COL_W-1:0]      i_centre_x,
    input  wire logic [ROW_W-1:0]      i_centre_y,
    input  wire logic [PIX_W-1:0]      i_blurred_alpha,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [PIX_W-1:0] a;
    } t_blur_px;

    logic [PIX_W-1:0]        line_hist [STORE_ROWS][MAX_WIDTH];
    logic [VSUM_W-1:0]       col_sum [MAX_WIDTH];
    logic [WT_W-1:0]         win_sum;
    logic [COL_W-1:0]        col_pos;
    logic [ROW_W-1:0]        row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    t_blur_px                blur_due [$];
    int                      fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    function automatic int fit_size(input int v, input int hi);
        if (v < KSIZE) return KSIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic blur_pixel(input logic [PIX_W-1:0] px);
        int       w, h, c, r, slot, vsum, avg, k;
        t_blur_px e;
        w    = fit_size(int'(width_reg), MAX_WIDTH);
        h    = fit_size(int'(height_reg), MAX_HEIGHT);
        c    = int'(col_pos);
        r    = int'(row_pos);
        slot = r % STORE_ROWS;
        vsum = int'(px);
        for (k = 0; k < STORE_ROWS; k++) vsum += int'(line_hist[k][c]);
        line_hist[slot][c] = px;

        if (c == 0)
            win_sum = WT_W'(vsum);
        else if (c < KSIZE)
            win_sum = WT_W'(int'(win_sum) + vsum);
        else
            win_sum = WT_W'(int'(win_sum) + vsum - int'(col_sum[c - KSIZE]));
        col_sum[c] = VSUM_W'(vsum);

        if (c >= KSIZE - 1 && r >= KSIZE - 1) begin
            avg = int'(win_sum) / DIVISOR;
            if (avg > ALPHA_MAX) avg = ALPHA_MAX;
            e.x = COL_W'(c - KERNEL_RADIUS);
            e.y = ROW_W'(r - KERNEL_RADIUS);
            e.a = PIX_W'(avg);
            blur_due.push_back(e);
        end

        if (c + 1 >= w) begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
        end else begin
            col_pos = COL_W'(c + 1);
        end
    endtask

    task automatic match_blur();
        t_blur_px e;
        if (blur_due.size() == 0) begin
            if (fails < 10)
                $display("[%0t] unexpected item: x=%0d y=%0d alpha=%0d", $realtime,
                         i_centre_x, i_centre_y, i_blurred_alpha);
            fails++;
        end else begin
            e = blur_due.pop_front();
            if (i_centre_x !== e.x || i_centre_y !== e.y || i_blurred_alpha !== e.a) begin
                if (fails < 10)
                    $display({"[%0t] mismatch: expected x=%0d y=%0d alpha=%0d, ",
                              "got x=%0d y=%0d alpha=%0d"},
                             $realtime, e.x, e.y, e.a,
                             i_centre_x, i_centre_y, i_blurred_alpha);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        int k, c;
        if (!i_rst_n) begin
            for (k = 0; k < STORE_ROWS; k++)
                for (c = 0; c < MAX_WIDTH; c++) line_hist[k][c] = '0;
            for (c = 0; c < MAX_WIDTH; c++) col_sum[c] = '0;
            win_sum    = '0;
            col_pos    = '0;
            row_pos    = '0;
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            blur_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_IMAGE_WIDTH)
                    width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                else if (i_cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
            end
            if (i_out_valid && !i_out_stall) match_blur();
            if (i_in_valid && !i_in_stall) blur_pixel(i_pixel_alpha);
        end
        o_fail_count <= fails;
        o_pending    <= blur_due.size();
    end

endmodule

`default_nettype wire

// ----- tb/box_blur_11x11_tb.sv -----
// Top of the box_blur_11x11 testbench: clock, reset, pixel stream, output stall
// and register writes; box_blur_11x11_chk does the checking. Depends on bbl_pkg.
`default_nettype none

module box_blur_11x11_tb
    import bbl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 1650;

    typedef enum int {MIX_UNIFORM, MIX_BRIGHT, MIX_BINARY, MIX_DARK, MIX_STRIPES} t_alpha_mix;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COL_W-1:0]      centre_x;
    logic [ROW_W-1:0]      centre_y;
    logic [PIX_W-1:0]      blurred;
    int                    fail_count;
    int                    pending;

    int         cycles     = 0;
    int         stall_hold = 0;
    logic       out_quiet  = 1'b0;
    logic       in_quiet   = 1'b0;
    t_alpha_mix pix_mix    = MIX_UNIFORM;
    int         items_sent = 0;
    int         pos_col    = 0;
    int         pos_row    = 0;
    int         eff_w      = 512;
    int         eff_h      = 256;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    box_blur_11x11 i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_pixel_alpha   (pixel),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_centre_x      (centre_x),
        .o_centre_y      (centre_y),
        .o_blurred_alpha (blurred)
    );

    box_blur_11x11_chk u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_pixel_alpha   (pixel),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_centre_x      (centre_x),
        .i_centre_y      (centre_y),
        .i_blurred_alpha (blurred),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("box_blur_11x11_tb: FAIL");
            $finish;
        end
    end

    // bursty back-pressure on the output
    always @(posedge clk) begin : back_pressure
        int r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (out_quiet) begin
                out_stall <= 1'b0;
                stall_hold = $urandom_range(1, 50);
            end else if (r < 65) begin
                out_stall <= 1'b0;
                stall_hold = $urandom_range(0, 8);
            end else if (r < 95) begin
                out_stall <= 1'b1;
                stall_hold = $urandom_range(0, 4);
            end else begin
                out_stall <= 1'b1;
                stall_hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int fit_size(input int v, input int hi);
        if (v < KSIZE) return KSIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] next_alpha(input t_alpha_mix mix, input int col);
        case (mix)
            MIX_BRIGHT:  return PIX_W'($urandom_range(224, 255));
            MIX_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            MIX_DARK:    return PIX_W'($urandom_range(0, 31));
            MIX_STRIPES: begin
                if (col >= 100 && col <= 140) return 8'hFF;
                if (col >= 200 && col <= 240) return 8'h00;
                if (col >= 300 && col <= 330) return (col % 2 == 0) ? 8'hFF : 8'h00;
                return PIX_W'($urandom_range(0, 255));
            end
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return CFG_DATA_W'($urandom_range(0, 10));
        if (r < 85) return CFG_DATA_W'($urandom_range(11, 32));
        return CFG_DATA_W'($urandom_range(33, 64));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return CFG_DATA_W'($urandom_range(0, 10));
        if (r < 90) return CFG_DATA_W'($urandom_range(11, 15));
        return CFG_DATA_W'($urandom_range(16, 22));
    endfunction

    task automatic send_pixel();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= next_alpha(pix_mix, pos_col);
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (pos_col + 1 >= eff_w) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= eff_h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    task automatic run_to_frame_end();
        do send_pixel(); while ((pos_col != 0 || pos_row != 0) && items_sent < ITEM_TARGET);
    endtask

    // block is idle once every result is out and the pipeline has emptied
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            eff_w = fit_size(int'(data[WIDTH_REG_W-1:0]), MAX_WIDTH);
        else
            eff_h = fit_size(int'(data[HEIGHT_REG_W-1:0]), MAX_HEIGHT);
    endtask

    task automatic shuffle_idling();
        in_quiet = ($urandom_range(0, 3) == 0);
        out_quiet <= ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        int n, r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wide frame first: every line store column used later gets written
        write_reg(REG_IMAGE_WIDTH, 13'd64);
        write_reg(REG_IMAGE_HEIGHT, 13'd5);
        pix_mix = MIX_STRIPES;
        run_to_frame_end();

        // tall frame cut short: height drops below the current row
        shuffle_idling();
        pix_mix = MIX_UNIFORM;
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        repeat (120) send_pixel();
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (105) send_pixel();
        write_reg(REG_IMAGE_HEIGHT, 13'd12);
        run_to_frame_end();

        // width shrinks below the current column, twice
        shuffle_idling();
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        repeat (40) send_pixel();
        write_reg(REG_IMAGE_WIDTH, 13'd30);
        while (!(pos_row == 3 && pos_col == 25)) send_pixel();
        write_reg(REG_IMAGE_WIDTH, 13'd15);
        run_to_frame_end();

        // smallest image: a single centre
        write_reg(REG_IMAGE_WIDTH, 13'd11);
        write_reg(REG_IMAGE_HEIGHT, 13'd11);
        pix_mix = MIX_BRIGHT;
        run_to_frame_end();
        pix_mix = MIX_BINARY;
        run_to_frame_end();

        while (items_sent < ITEM_TARGET) begin
            shuffle_idling();
            pix_mix = t_alpha_mix'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7) write_reg(REG_IMAGE_WIDTH, pick_width());
            if ($urandom_range(0, 9) < 6) write_reg(REG_IMAGE_HEIGHT, pick_height());
            r = $urandom_range(0, 99);
            if (r < 15) begin
                n = $urandom_range(1, eff_w * eff_h - 1);
                repeat (n) begin
                    if (items_sent < ITEM_TARGET) send_pixel();
                end
            end else begin
                run_to_frame_end();
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("box_blur_11x11_tb: PASS");
        else
            $display("box_blur_11x11_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
